@@ rtl/mlpq_pkg.sv @@
// Shared sizes, codes and types of the multilevel priority queue.
package mlpq_pkg;

  localparam int LEVELS = 16;
  localparam int DEPTH  = 32;

  localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = PTR_W + 1;
  localparam int WORDS  = LEVELS * DEPTH;
  localparam int ADDR_W = $clog2(WORDS);
  localparam int DATA_W = 32;

  typedef enum logic {
    ACT_ENQ = 1'b0,
    ACT_DEQ = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_BADLEVEL = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_e;

  // Pointer update for one level: push bumps the count, pop advances the head and lowers the count.
  typedef struct packed {
    logic             en;
    logic             pop;
    logic [LVL_W-1:0] lvl;
  } lvl_upd_t;

endpackage

@@ rtl/multilevel_priority_queue.sv @@
// Multilevel priority queue: one ring FIFO per level in a shared entry RAM.
//
// Input channel (in_valid_i / in_ready_o) takes one request: action_i = 0
// appends value_i to level level_i, action_i = 1 removes the front of the
// lowest-numbered non-empty level. Output channel (out_valid_o / out_ready_i)
// returns exactly one result per request: status_o, data_out_o, level_out_o.
// Enqueue, rejected and empty-queue requests write the output register directly:
// the result is valid the cycle after acceptance. A successful dequeue reads
// the entry RAM into its read register (state S_READ), then loads the output
// register from it. One request is in flight at a time, so a new request
// is taken only once the previous one is done. Reset clears all head pointers
// and fill counts, so every level is empty; RAM contents need no clearing.
// A stalled result holds in the output register and new requests wait until
// it is taken (a request can be accepted in the same cycle as the pending
// result is taken).
module multilevel_priority_queue
  import mlpq_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     action_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic [4:0]               level_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [1:0]               status_o,
  output logic signed [DATA_W-1:0] data_out_o,
  output logic [3:0]               level_out_o
);

  state_e state_q, state_d;

  logic                     out_valid_q, out_valid_d;
  logic [1:0]               status_q, status_d;
  logic signed [DATA_W-1:0] data_q, data_d;
  logic [3:0]               lvl_out_q, lvl_out_d;
  logic [LVL_W-1:0]         pend_lvl_q, pend_lvl_d;

  logic             accept;
  logic             bad_level;
  logic [LVL_W-1:0] sel_lvl;
  logic [PTR_W-1:0] head;
  logic [CNT_W-1:0] count;
  logic [LVL_W-1:0] first_lvl;
  logic             any_nonempty;
  logic [SUM_W-1:0] slot_sum;
  logic [PTR_W-1:0] slot;
  lvl_upd_t         upd;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  assign bad_level = ({1'b0, level_i} >= 6'(LEVELS));
  assign sel_lvl   = (action_e'(action_i) == ACT_DEQ) ? first_lvl : LVL_W'(level_i);

  mlpq_level_table u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_lvl_i    (sel_lvl),
    .upd_i       (upd),
    .head_o      (head),
    .count_o     (count),
    .first_lvl_o (first_lvl),
    .any_o       (any_nonempty)
  );

  // Tail slot = (head + count) mod DEPTH; the sum stays below 2*DEPTH.
  assign slot_sum  = SUM_W'(head) + SUM_W'(count);
  assign slot      = (slot_sum >= SUM_W'(DEPTH)) ? PTR_W'(slot_sum - SUM_W'(DEPTH))
                                                 : PTR_W'(slot_sum);
  assign ram_waddr = ADDR_W'(sel_lvl) * ADDR_W'(DEPTH) + ADDR_W'(slot);
  assign ram_raddr = ADDR_W'(sel_lvl) * ADDR_W'(DEPTH) + ADDR_W'(head);

  mlpq_ram #(
    .DATA_W (DATA_W),
    .WORDS  (WORDS),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (value_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    data_d      = data_q;
    lvl_out_d   = lvl_out_q;
    pend_lvl_d  = pend_lvl_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    upd         = '{en: 1'b0, pop: 1'b0, lvl: sel_lvl};

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (action_e'(action_i) == ACT_ENQ) begin
            out_valid_d = 1'b1;
            data_d      = '0;
            if (bad_level) begin
              status_d  = ST_BADLEVEL;
              lvl_out_d = '0;
            end else if (count == CNT_W'(DEPTH)) begin
              status_d  = ST_FULL;
              lvl_out_d = 4'(sel_lvl);
            end else begin
              status_d  = ST_OK;
              lvl_out_d = 4'(sel_lvl);
              ram_we    = 1'b1;
              upd.en    = 1'b1;
            end
          end else if (!any_nonempty) begin
            out_valid_d = 1'b1;
            status_d    = ST_EMPTY;
            data_d      = '0;
            lvl_out_d   = '0;
          end else begin
            // Read the front entry into the RAM read register and advance the head; S_READ loads the result.
            ram_re     = 1'b1;
            upd.en     = 1'b1;
            upd.pop    = 1'b1;
            pend_lvl_d = sel_lvl;
            state_d    = S_READ;
          end
        end
      end
      S_READ: begin
        out_valid_d = 1'b1;
        status_d    = ST_OK;
        data_d      = ram_rdata;
        lvl_out_d   = 4'(pend_lvl_q);
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q   <= status_d;
    data_q     <= data_d;
    lvl_out_q  <= lvl_out_d;
    pend_lvl_q <= pend_lvl_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign data_out_o  = data_q;
  assign level_out_o = lvl_out_q;

endmodule

@@ rtl/mlpq_ram.sv @@
// Simple dual-port synchronous RAM with registered read data.
module mlpq_ram #(
  parameter int DATA_W = 32,
  parameter int WORDS  = 512,
  parameter int ADDR_W = 9
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [WORDS];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/mlpq_level_table.sv @@
// Per-level head pointers and fill counts, plus the lowest non-empty level search.
module mlpq_level_table
  import mlpq_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [LVL_W-1:0] rd_lvl_i,
  input  lvl_upd_t         upd_i,
  output logic [PTR_W-1:0] head_o,
  output logic [CNT_W-1:0] count_o,
  output logic [LVL_W-1:0] first_lvl_o,
  output logic             any_o
);

  logic [PTR_W-1:0] head_q [LEVELS];
  logic [CNT_W-1:0] cnt_q  [LEVELS];
  logic [PTR_W-1:0] head_d;
  logic [CNT_W-1:0] cnt_d;
  logic [LEVELS-1:0] nonempty;

  assign head_o  = head_q[rd_lvl_i];
  assign count_o = cnt_q[rd_lvl_i];

  always_comb begin
    for (int i = 0; i < LEVELS; i++) begin
      nonempty[i] = (cnt_q[i] != '0);
    end
    any_o       = |nonempty;
    first_lvl_o = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (nonempty[i]) begin
        first_lvl_o = LVL_W'(i);
      end
    end
  end

  always_comb begin
    head_d = head_q[upd_i.lvl];
    cnt_d  = cnt_q[upd_i.lvl];
    if (upd_i.pop) begin
      head_d = (head_q[upd_i.lvl] == PTR_W'(DEPTH - 1)) ? '0
             : head_q[upd_i.lvl] + PTR_W'(1);
      cnt_d  = cnt_q[upd_i.lvl] - CNT_W'(1);
    end else begin
      cnt_d  = cnt_q[upd_i.lvl] + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LEVELS; i++) begin
        head_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else if (upd_i.en) begin
      head_q[upd_i.lvl] <= head_d;
      cnt_q[upd_i.lvl]  <= cnt_d;
    end
  end

endmodule
